>>> rtl/implicit_array_bst_insert_search_unit_macros.svh
// Assertion macros for the implicit array BST unit.
// Both expect clk and rst_n in scope.
`ifndef IMPLICIT_ARRAY_BST_INSERT_SEARCH_UNIT_MACROS_SVH
`define IMPLICIT_ARRAY_BST_INSERT_SEARCH_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define IABST_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define IABST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define IABST_ASSERT_IMPLIES(label, ante, cons)

`define IABST_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/iabst_pkg.sv
`timescale 1ns / 1ps

package iabst_pkg;

    localparam int KEY_PORT_BITS = 16;
    localparam int INDEX_BITS    = 10;

    localparam logic [2:0] CODE_LEFT      = 3'd0;
    localparam logic [2:0] CODE_RIGHT     = 3'd1;
    localparam logic [2:0] CODE_FOUND     = 3'd2;
    localparam logic [2:0] CODE_NOT_FOUND = 3'd3;
    localparam logic [2:0] CODE_INSERTED  = 3'd4;
    localparam logic [2:0] CODE_DUPLICATE = 3'd5;
    localparam logic [2:0] CODE_NO_ROOM   = 3'd6;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [KEY_PORT_BITS-1:0] key;
    } in_t;

    typedef struct packed {
        logic [2:0]            code;
        logic [INDEX_BITS-1:0] node_index;
        logic                  last;
    } out_t;

endpackage

>>> rtl/iabst_cell.sv
`timescale 1ns / 1ps

// One tree level: holds the 2^LEVEL nodes of that level and compares one node
// per walk, handing the child offset to the next level.
module iabst_cell #(
    parameter int LEVEL       = 0,
    parameter int TREE_LEVELS = 10,
    parameter int KEY_BITS    = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   clr_en,
    input  logic [TREE_LEVELS-2:0] clr_addr,
    input  logic                   go,
    input  logic [TREE_LEVELS-1:0] off_in,
    input  logic                   mode,
    input  logic [KEY_BITS-1:0]    key,
    output logic                   go_out,
    output logic [TREE_LEVELS-1:0] off_out,
    output logic                   emit,
    output iabst_pkg::out_t        res
);

    localparam int AW = (LEVEL == 0) ? 1 : LEVEL;
    localparam longint unsigned DEPTH = 64'd1 << LEVEL;
    localparam logic [AW-1:0] ADDR_MASK = AW'(DEPTH - 64'd1);
    localparam logic BOTTOM = (LEVEL == TREE_LEVELS - 1);

    logic [KEY_BITS:0] mem [DEPTH];

    logic                act_reg;
    logic [AW-1:0]       off_reg;
    logic                rd_valid_reg;
    logic [KEY_BITS-1:0] rd_key_reg;

    logic          wr_en;
    logic          dir;
    logic [63:0]   pos;
    logic [AW-1:0] clr_a;

    assign clr_a = AW'(clr_addr) & ADDR_MASK;
    assign pos   = (64'd1 << LEVEL) | 64'(off_reg);

    always_ff @(posedge clk)
    begin
        if (clr_en)
        begin
            mem[clr_a] <= '0;
        end
        else if (wr_en)
        begin
            mem[off_reg] <= {1'b1, key};
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            {rd_valid_reg, rd_key_reg} <= mem[off_in[AW-1:0]];
            off_reg                    <= off_in[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= go;
        end
    end

    always_comb
    begin
        wr_en          = 1'b0;
        go_out         = 1'b0;
        off_out        = '0;
        emit           = 1'b0;
        dir            = (rd_key_reg < key);
        res.code       = iabst_pkg::CODE_LEFT;
        res.node_index = pos[iabst_pkg::INDEX_BITS-1:0];
        res.last       = 1'b1;
        if (act_reg)
        begin
            emit = 1'b1;
            if (!rd_valid_reg)
            begin
                if (mode == iabst_pkg::MODE_INSERT)
                begin
                    wr_en    = 1'b1;
                    res.code = iabst_pkg::CODE_INSERTED;
                end
                else
                begin
                    res.code = iabst_pkg::CODE_NOT_FOUND;
                end
            end
            else if (rd_key_reg == key)
            begin
                res.code = (mode == iabst_pkg::MODE_INSERT) ? iabst_pkg::CODE_DUPLICATE
                                                            : iabst_pkg::CODE_FOUND;
            end
            else if (BOTTOM)
            begin
                res.code = (mode == iabst_pkg::MODE_INSERT) ? iabst_pkg::CODE_NO_ROOM
                                                            : iabst_pkg::CODE_NOT_FOUND;
            end
            else
            begin
                go_out   = 1'b1;
                off_out  = (TREE_LEVELS'(off_reg) << 1) | TREE_LEVELS'(dir);
                // inserts descend silently, searches report each step
                emit     = (mode == iabst_pkg::MODE_SEARCH);
                res.code = dir ? iabst_pkg::CODE_RIGHT : iabst_pkg::CODE_LEFT;
                res.last = 1'b0;
            end
        end
    end

endmodule

>>> rtl/implicit_array_bst_insert_search_unit.sv
`timescale 1ns / 1ps

// Binary search tree in heap order, one cell per tree level. A request is taken
// when start is high and busy is low; the walk then moves down one level per
// clock, each cell reading its own node memory. Busy stays high until the final
// result of an item is registered; that result is on result in the first cycle
// that busy is low again. A search puts out one step result per level descended,
// one per cycle, then a final result; an insert puts out one result. Every result
// is on result for exactly one cycle with result_valid high and must be taken
// then: there is no stall input. After reset the node store is cleared while busy
// stays high.
`include "implicit_array_bst_insert_search_unit_macros.svh"

module implicit_array_bst_insert_search_unit #(
    parameter int TREE_LEVELS = 10,
    parameter int KEY_BITS    = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  iabst_pkg::in_t  request,
    output logic            result_valid,
    output iabst_pkg::out_t result
);

    logic                   clearing_reg;
    logic [TREE_LEVELS-2:0] clr_cnt_reg;
    logic                   walk_reg;
    iabst_pkg::in_t         req_reg;
    iabst_pkg::out_t        result_reg;
    logic                   result_valid_reg;

    logic                   accept;
    logic                   hand_go [TREE_LEVELS+1];
    logic [TREE_LEVELS-1:0] hand_off [TREE_LEVELS+1];
    logic [TREE_LEVELS-1:0] emit_vec;
    iabst_pkg::out_t        cell_res [TREE_LEVELS];
    logic                   emit_any;
    iabst_pkg::out_t        res_any;
    logic [KEY_BITS-1:0]    walk_key;

    assign busy         = clearing_reg || walk_reg;
    assign accept       = start && !busy;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign walk_key     = KEY_BITS'(req_reg.key);
    assign hand_go[0]   = accept;
    assign hand_off[0]  = '0;

    for (genvar l = 0; l < TREE_LEVELS; l++)
    begin : g_level
        iabst_cell #(
            .LEVEL       (l),
            .TREE_LEVELS (TREE_LEVELS),
            .KEY_BITS    (KEY_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clr_en   (clearing_reg),
            .clr_addr (clr_cnt_reg),
            .go       (hand_go[l]),
            .off_in   (hand_off[l]),
            .mode     (req_reg.mode),
            .key      (walk_key),
            .go_out   (hand_go[l+1]),
            .off_out  (hand_off[l+1]),
            .emit     (emit_vec[l]),
            .res      (cell_res[l])
        );
    end

    // only the active level emits, so an OR of the gated results suffices
    always_comb
    begin
        emit_any = 1'b0;
        res_any  = '0;
        for (int l = 0; l < TREE_LEVELS; l++)
        begin
            if (emit_vec[l])
            begin
                res_any = res_any | cell_res[l];
            end
            emit_any = emit_any | emit_vec[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg     <= 1'b1;
            clr_cnt_reg      <= '0;
            walk_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                walk_reg <= 1'b1;
            end
            else if (emit_any && res_any.last)
            begin
                walk_reg <= 1'b0;
            end
            result_valid_reg <= emit_any;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        result_reg <= res_any;
    end

    `IABST_ASSERT_IMPLIES(a_one_level_emits, 1'b1, $onehot0(emit_vec))
    `IABST_ASSERT_NEXT(a_accept_holds_busy, accept, busy)
    `IABST_ASSERT_IMPLIES(a_step_keeps_busy, result_valid && !result.last, busy)
    `IABST_ASSERT_IMPLIES(a_quiet_while_clearing, clearing_reg, !result_valid && !walk_reg)
    `IABST_ASSERT_IMPLIES(a_stop_at_bottom, hand_go[TREE_LEVELS] || |hand_off[TREE_LEVELS], 1'b0)

endmodule
